[rtl/core/matrix_multiply_unit_macros.svh]
// assertion macros for the matrix multiply unit
// no dependencies; included by the rtl files that carry assertions
`ifndef MATRIX_MULTIPLY_UNIT_MACROS_SVH
`define MATRIX_MULTIPLY_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// checked property, switched off while reset is held
`define MMU_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("matrix multiply unit property failed");
// checked property, live through reset as well
`define MMU_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("matrix multiply unit property failed");
`else
`define MMU_ASSERT(label, clk, rst_n, prop)
`define MMU_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

[rtl/core/mmu_pkg.sv]
// shared types and constants of the matrix multiply unit
// no dependencies
package mmu_pkg;

  // fixed field widths
  localparam int OPCODE_W   = 2;
  localparam int IDX_PORT_W = 4;
  localparam int VALUE_W    = 16;
  localparam int SUM_W      = 36;
  localparam int CFG_W      = 5;
  localparam int CFG_IDX_W  = 2;

  // size registers come out of reset at sixteen
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // item opcodes; the unused code is rejected
  typedef enum logic [OPCODE_W-1:0] {
    OP_WR_LEFT  = 2'd0,
    OP_WR_RIGHT = 2'd1,
    OP_COMPUTE  = 2'd2
  } opcode_e;

  // size register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_A     = 2'd0,
    CFG_INNER_SIZE = 2'd1,
    CFG_COLS_B     = 2'd2
  } cfg_idx_e;

endpackage

[rtl/core/matrix_multiply_unit.sv]
// Matrix multiply unit: two element stores and one shared multiply-accumulate.
// Load words give no result; a rejected word gives one error result in the cycle
// after it is taken. A row compute gives one result per result column, in column
// order, and busy stays high until the last of them is shown: one product per
// cycle, set by the single read port of each store. Reset clears control and the
// result register, not the stores or the pipe data.
`include "matrix_multiply_unit_macros.svh"

module matrix_multiply_unit #(
  parameter int MAX_DIM    = 16,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  output logic                                   busy_o,
  input  logic [mmu_pkg::OPCODE_W-1:0]           opcode_i,
  input  logic [mmu_pkg::IDX_PORT_W-1:0]         row_i,
  input  logic [mmu_pkg::IDX_PORT_W-1:0]         col_i,
  input  logic signed [mmu_pkg::VALUE_W-1:0]     value_i,
  input  logic                                   cfg_we_i,
  input  logic [mmu_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [mmu_pkg::CFG_W-1:0]              cfg_data_i,
  output logic                                   result_valid_o,
  output logic [mmu_pkg::IDX_PORT_W-1:0]         out_row_o,
  output logic [mmu_pkg::IDX_PORT_W-1:0]         out_col_o,
  output logic signed [mmu_pkg::SUM_W-1:0]       product_sum_o,
  output logic                                   error_o,
  output logic                                   last_o
);

  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int CMP_W  = (DIM_W > mmu_pkg::IDX_PORT_W) ? DIM_W : mmu_pkg::IDX_PORT_W;
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int PROD_W = 2 * ELEM_WIDTH;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  // tag carried down the multiply-accumulate pipe
  typedef struct packed {
    logic             first;
    logic             last_k;
    logic             last_c;
    logic [IDX_W-1:0] col;
  } tag_t;

  // a size of zero acts as one, above the store size as the store size
  function automatic logic [DIM_W-1:0] eff_dim(input logic [mmu_pkg::CFG_W-1:0] raw);
    logic [DIM_W-1:0] r;
    if (raw == '0) begin
      r = DIM_W'(1);
    end else if (int'(raw) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(raw);
    end
    return r;
  endfunction

  logic [mmu_pkg::CFG_W-1:0] rows_a_q, inner_size_q, cols_b_q;
  logic [DIM_W-1:0]          ra, ki, cb;
  logic [IDX_W-1:0]          ki_last, cb_last;
  logic                      accept;
  logic                      wr_left, wr_right, cmp_ok, item_err;
  logic [ADDR_W-1:0]         wr_addr;
  logic [ELEM_WIDTH-1:0]     wr_data;

  state_e                       state_q;
  logic [IDX_W-1:0]             k_q, c_q;
  logic [mmu_pkg::IDX_PORT_W-1:0] row_q;
  logic [ADDR_W-1:0]            rd_addr_a, rd_addr_b;
  tag_t                         issue_tag;

  logic [ELEM_WIDTH-1:0] left_mem  [DEPTH];
  logic [ELEM_WIDTH-1:0] right_mem [DEPTH];
  logic [ELEM_WIDTH-1:0] rd_a_q, rd_b_q;

  logic                     s1_valid_q, s2_valid_q;
  tag_t                     s1_tag_q, s2_tag_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [mmu_pkg::SUM_W-1:0] acc_q, acc_sum, prod_ext;

  logic                           result_valid_q, error_q, last_q;
  logic [mmu_pkg::IDX_PORT_W-1:0] out_row_q, out_col_q;
  logic signed [mmu_pkg::SUM_W-1:0] sum_q;

  // size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q     <= mmu_pkg::CFG_RESET;
      inner_size_q <= mmu_pkg::CFG_RESET;
      cols_b_q     <= mmu_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mmu_pkg::CFG_ROWS_A:     rows_a_q     <= cfg_data_i;
        mmu_pkg::CFG_INNER_SIZE: inner_size_q <= cfg_data_i;
        mmu_pkg::CFG_COLS_B:     cols_b_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign ra      = eff_dim(rows_a_q);
  assign ki      = eff_dim(inner_size_q);
  assign cb      = eff_dim(cols_b_q);
  assign ki_last = IDX_W'(ki - DIM_W'(1));
  assign cb_last = IDX_W'(cb - DIM_W'(1));

  // word decode and range checks
  assign busy_o = (state_q == ST_RUN) | s1_valid_q | s2_valid_q;
  assign accept = start_i & ~busy_o;

  always_comb begin
    wr_left  = 1'b0;
    wr_right = 1'b0;
    cmp_ok   = 1'b0;
    case (opcode_i)
      mmu_pkg::OP_WR_LEFT: begin
        wr_left = (CMP_W'(row_i) < CMP_W'(ra)) && (CMP_W'(col_i) < CMP_W'(ki));
      end
      mmu_pkg::OP_WR_RIGHT: begin
        wr_right = (CMP_W'(row_i) < CMP_W'(ki)) && (CMP_W'(col_i) < CMP_W'(cb));
      end
      mmu_pkg::OP_COMPUTE: begin
        cmp_ok = CMP_W'(row_i) < CMP_W'(ra);
      end
      default: ;
    endcase
  end

  assign item_err = accept & ~(wr_left | wr_right | cmp_ok);
  assign wr_addr  = {IDX_W'(row_i), IDX_W'(col_i)};
  assign wr_data  = ELEM_WIDTH'(value_i);

  // read addresses of the current step; busy keeps loads off the stores meanwhile
  assign rd_addr_a = {IDX_W'(row_q), k_q};
  assign rd_addr_b = {k_q, c_q};
  assign issue_tag = '{first:  (k_q == '0),
                       last_k: (k_q == ki_last),
                       last_c: (c_q == cb_last),
                       col:    c_q};

  // left element store
  always_ff @(posedge clk_i) begin
    if (accept && wr_left) begin
      left_mem[wr_addr] <= wr_data;
    end
    rd_a_q <= left_mem[rd_addr_a];
  end

  // right element store
  always_ff @(posedge clk_i) begin
    if (accept && wr_right) begin
      right_mem[wr_addr] <= wr_data;
    end
    rd_b_q <= right_mem[rd_addr_b];
  end

  // pipe valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= (state_q == ST_RUN);
      s2_valid_q <= s1_valid_q;
    end
  end

  // multiply and accumulate
  assign prod_ext = mmu_pkg::SUM_W'(prod_q);
  assign acc_sum  = s2_tag_q.first ? prod_ext : acc_q + prod_ext;

  always_ff @(posedge clk_i) begin
    s1_tag_q <= issue_tag;
    s2_tag_q <= s1_tag_q;
    prod_q   <= PROD_W'($signed(rd_a_q)) * PROD_W'($signed(rd_b_q));
    if (s2_valid_q) begin
      acc_q <= acc_sum;
    end
  end

  // step sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      k_q            <= '0;
      c_q            <= '0;
      row_q          <= '0;
      result_valid_q <= 1'b0;
      out_row_q      <= '0;
      out_col_q      <= '0;
      sum_q          <= '0;
      error_q        <= 1'b0;
      last_q         <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept && cmp_ok) begin
            state_q <= ST_RUN;
            k_q     <= '0;
            c_q     <= '0;
            row_q   <= row_i;
          end
        end
        ST_RUN: begin
          if (k_q == ki_last) begin
            k_q <= '0;
            if (c_q == cb_last) begin
              state_q <= ST_IDLE;
            end else begin
              c_q <= c_q + IDX_W'(1);
            end
          end else begin
            k_q <= k_q + IDX_W'(1);
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      if (s2_valid_q && s2_tag_q.last_k) begin
        result_valid_q <= 1'b1;
        out_row_q      <= row_q;
        out_col_q      <= mmu_pkg::IDX_PORT_W'(s2_tag_q.col);
        sum_q          <= acc_sum;
        error_q        <= 1'b0;
        last_q         <= s2_tag_q.last_c;
      end else if (item_err) begin
        result_valid_q <= 1'b1;
        out_row_q      <= row_i;
        out_col_q      <= col_i;
        sum_q          <= '0;
        error_q        <= 1'b1;
        last_q         <= 1'b1;
      end else begin
        result_valid_q <= 1'b0;
      end
    end
  end

  assign result_valid_o = result_valid_q;
  assign out_row_o      = out_row_q;
  assign out_col_o      = out_col_q;
  assign product_sum_o  = sum_q;
  assign error_o        = error_q;
  assign last_o         = last_q;

  // checks
  `MMU_ASSERT(a_compute_enters_run, clk_i, rst_ni, accept && cmp_ok |=> state_q == ST_RUN)
  `MMU_ASSERT(a_final_column_is_last, clk_i, rst_ni, s2_valid_q && s2_tag_q.last_k && s2_tag_q.last_c |=> result_valid_o && last_o && !error_o)
  `MMU_ASSERT(a_reject_gives_error, clk_i, rst_ni, item_err |=> result_valid_o && error_o && last_o)
  `MMU_ASSERT(a_busy_ends_on_last, clk_i, rst_ni, $fell(busy_o) |-> result_valid_o && last_o)
  `MMU_ASSERT_ALWAYS(a_error_is_clean, clk_i, result_valid_o && error_o |-> last_o && product_sum_o == '0)

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// self-checking testbench for the matrix multiply unit: load and row-compute words
// checked against an in-bench model of the two element stores; needs mmu_pkg and the rtl
module testbench;
  import mmu_pkg::*;

  localparam int DIM = 16;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_OFF = 4;
  localparam int TIMEOUT_NS = 5_000_000;

  // corner element values used by the directed loads
  localparam logic signed [VALUE_W-1:0] EDGE_VALS [6] = '{
    16'sh7fff, 16'sh8000, -16'sd1, 16'sd1, 16'sd0, 16'sd12345
  };

  typedef struct packed {
    logic [OPCODE_W-1:0]          opcode;
    logic [IDX_PORT_W-1:0]        row;
    logic [IDX_PORT_W-1:0]        col;
    logic signed [VALUE_W-1:0]    value;
  } mm_word_t;

  typedef struct packed {
    logic [IDX_PORT_W-1:0]        row;
    logic [IDX_PORT_W-1:0]        col;
    logic signed [SUM_W-1:0]      sum;
    logic                         error;
    logic                         last;
  } mm_result_t;

  logic                         clk_i;
  logic                         rst_ni = 1'b0;
  logic                         start_i = 1'b0;
  logic                         busy_o;
  logic [OPCODE_W-1:0]          opcode_i = '0;
  logic [IDX_PORT_W-1:0]        row_i = '0;
  logic [IDX_PORT_W-1:0]        col_i = '0;
  logic signed [VALUE_W-1:0]    value_i = '0;
  logic                         cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_idx_i = '0;
  logic [CFG_W-1:0]             cfg_data_i = '0;
  logic                         result_valid_o;
  logic [IDX_PORT_W-1:0]        out_row_o;
  logic [IDX_PORT_W-1:0]        out_col_o;
  logic signed [SUM_W-1:0]      product_sum_o;
  logic                         error_o;
  logic                         last_o;

  // words waiting to go out, and sums still owed by the block
  mm_word_t   word_q[$];
  mm_result_t owed_sums_q[$];

  // model copy of the size registers and of both stores
  logic [CFG_W-1:0]          rows_reg  = CFG_RESET;
  logic [CFG_W-1:0]          inner_reg = CFG_RESET;
  logic [CFG_W-1:0]          cols_reg  = CFG_RESET;
  logic signed [VALUE_W-1:0] left_mem  [DIM*DIM];
  logic signed [VALUE_W-1:0] right_mem [DIM*DIM];
  // which elements the generated stream has loaded so far
  bit                        left_set  [DIM*DIM];
  bit                        right_set [DIM*DIM];

  int idle_pct = 0;
  int fail_count = 0;
  int words_queued = 0;
  int words_taken = 0;
  int computes_taken = 0;
  int rejects_taken = 0;
  int results_checked = 0;

  matrix_multiply_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .opcode_i       (opcode_i),
    .row_i          (row_i),
    .col_i          (col_i),
    .value_i        (value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .product_sum_o  (product_sum_o),
    .error_o        (error_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // zero acts as one, anything past the store size acts as the store size
  function automatic int eff_dim(logic [CFG_W-1:0] r);
    if (r == 0) return 1;
    if (r > DIM) return DIM;
    return int'(r);
  endfunction

  // update the stores for one taken word and queue the sums it owes
  task automatic predict_word(mm_word_t w);
    int ra, ki, cb;
    logic signed [SUM_W-1:0] acc;
    logic signed [31:0]      prod;
    mm_result_t res;
    ra = eff_dim(rows_reg);
    ki = eff_dim(inner_reg);
    cb = eff_dim(cols_reg);
    case (w.opcode)
      OP_WR_LEFT: begin
        if (w.row < ra && w.col < ki) begin
          left_mem[w.row*DIM + w.col] = w.value;
          return;
        end
      end
      OP_WR_RIGHT: begin
        if (w.row < ki && w.col < cb) begin
          right_mem[w.row*DIM + w.col] = w.value;
          return;
        end
      end
      OP_COMPUTE: begin
        if (w.row < ra) begin
          for (int c = 0; c < cb; c++) begin
            acc = '0;
            for (int k = 0; k < ki; k++) begin
              prod = left_mem[w.row*DIM + k] * right_mem[k*DIM + c];
              acc  = acc + prod;
            end
            res.row   = w.row;
            res.col   = c[IDX_PORT_W-1:0];
            res.sum   = acc;
            res.error = 1'b0;
            res.last  = (c == cb - 1);
            owed_sums_q.push_back(res);
          end
          computes_taken++;
          return;
        end
      end
      default: ;
    endcase
    // rejected word: one error result echoing the indexes
    res.row   = w.row;
    res.col   = w.col;
    res.sum   = '0;
    res.error = 1'b1;
    res.last  = 1'b1;
    owed_sums_q.push_back(res);
    rejects_taken++;
  endtask

  // append one word and note which elements it leaves defined
  function automatic void queue_word(logic [OPCODE_W-1:0] op, int row, int col,
                                     logic signed [VALUE_W-1:0] value);
    mm_word_t w;
    int ra, ki, cb;
    ra = eff_dim(rows_reg);
    ki = eff_dim(inner_reg);
    cb = eff_dim(cols_reg);
    if (op == OP_WR_LEFT && row < ra && col < ki) left_set[row*DIM + col] = 1'b1;
    if (op == OP_WR_RIGHT && row < ki && col < cb) right_set[row*DIM + col] = 1'b1;
    w.opcode = op;
    w.row    = row[IDX_PORT_W-1:0];
    w.col    = col[IDX_PORT_W-1:0];
    w.value  = value;
    word_q.push_back(w);
    words_queued++;
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_elem();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sd0;
      3:       return -16'sd1;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // a row compute, preceded by loads of any element it reads that is still unset
  function automatic void queue_row_compute(int row);
    int ki, cb;
    ki = eff_dim(inner_reg);
    cb = eff_dim(cols_reg);
    for (int k = 0; k < ki; k++)
      if (!left_set[row*DIM + k]) queue_word(OP_WR_LEFT, row, k, pick_elem());
    for (int k = 0; k < ki; k++)
      for (int c = 0; c < cb; c++)
        if (!right_set[k*DIM + c]) queue_word(OP_WR_RIGHT, k, c, pick_elem());
    queue_word(OP_COMPUTE, row, $urandom_range(0, DIM-1), VALUE_W'($urandom));
  endfunction

  // mostly loads and well-formed computes, the rest rejects and noise
  function automatic void queue_random_words(int n);
    int target, pick, ra, ki, cb;
    target = words_queued + n;
    while (words_queued < target) begin
      ra   = eff_dim(rows_reg);
      ki   = eff_dim(inner_reg);
      cb   = eff_dim(cols_reg);
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        if ($urandom_range(0, 1))
          queue_word(OP_WR_LEFT, $urandom_range(0, ra-1), $urandom_range(0, ki-1),
                     pick_elem());
        else
          queue_word(OP_WR_RIGHT, $urandom_range(0, ki-1), $urandom_range(0, cb-1),
                     pick_elem());
      end else if (pick < 80) begin
        queue_row_compute($urandom_range(0, ra-1));
      end else if (pick < 88) begin
        if (ra < DIM)
          queue_word(OP_COMPUTE, $urandom_range(ra, DIM-1), $urandom_range(0, DIM-1),
                     VALUE_W'($urandom));
        else
          queue_word(OP_UNUSED, $urandom_range(0, DIM-1), $urandom_range(0, DIM-1),
                     VALUE_W'($urandom));
      end else if (pick < 95) begin
        // loads anywhere on the index ports, mostly out of range on small sizes
        queue_word($urandom_range(0, 1) ? OP_WR_RIGHT : OP_WR_LEFT,
                   $urandom_range(0, DIM-1), $urandom_range(0, DIM-1), pick_elem());
      end else begin
        queue_word(OP_UNUSED, $urandom_range(0, DIM-1), $urandom_range(0, DIM-1),
                   VALUE_W'($urandom));
      end
    end
  endfunction

  // write all three size registers on consecutive edges
  task automatic write_sizes(logic [CFG_W-1:0] r, logic [CFG_W-1:0] k,
                             logic [CFG_W-1:0] c, int idle);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_ROWS_A;
    cfg_data_i <= r;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_INNER_SIZE;
    cfg_data_i <= k;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_COLS_B;
    cfg_data_i <= c;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    rows_reg  = r;
    inner_reg = k;
    cols_reg  = c;
    idle_pct  = idle;
  endtask

  // wait for every word taken and every owed sum seen, then a short hold-off
  task automatic settle(int extra);
    while (word_q.size() != 0 || start_i || owed_sums_q.size() != 0 || busy_o)
      @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // word driver: hold while busy, otherwise offer the next word unless idling
  always @(posedge clk_i or negedge rst_ni) begin : drive_words
    mm_word_t w;
    if (!rst_ni) begin
      start_i  <= 1'b0;
      opcode_i <= '0;
      row_i    <= '0;
      col_i    <= '0;
      value_i  <= '0;
    end else begin
      if (start_i && !busy_o) begin
        predict_word({opcode_i, row_i, col_i, value_i});
        words_taken++;
      end
      if (!start_i || !busy_o) begin
        if (word_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          w = word_q.pop_front();
          start_i  <= 1'b1;
          opcode_i <= w.opcode;
          row_i    <= w.row;
          col_i    <= w.col;
          value_i  <= w.value;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // result monitor: every strobe is checked against the oldest owed sum
  always @(posedge clk_i) begin : check_results
    mm_result_t want;
    if (rst_ni && result_valid_o) begin
      if (owed_sums_q.size() == 0) begin
        $error("result with nothing owed: row %0d col %0d sum %0d",
               out_row_o, out_col_o, product_sum_o);
        fail_count++;
      end else begin
        want = owed_sums_q.pop_front();
        results_checked++;
        if (out_row_o !== want.row) begin
          $error("out_row mismatch: expected %0d, got %0d", want.row, out_row_o);
          fail_count++;
        end
        if (out_col_o !== want.col) begin
          $error("out_col mismatch: expected %0d, got %0d", want.col, out_col_o);
          fail_count++;
        end
        if (product_sum_o !== want.sum) begin
          $error("product_sum mismatch: expected %0d, got %0d", want.sum, product_sum_o);
          fail_count++;
        end
        if (error_o !== want.error) begin
          $error("error mismatch: expected %0d, got %0d", want.error, error_o);
          fail_count++;
        end
        if (last_o !== want.last) begin
          $error("last mismatch: expected %0d, got %0d", want.last, last_o);
          fail_count++;
        end
      end
    end
  end

  // stimulus: directed corners, then random phases over several size settings
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: 2x3 by 3x2 with corner values, then every kind of reject
    write_sizes(5'd2, 5'd3, 5'd2, 0);
    for (int i = 0; i < 6; i++) begin
      queue_word(OP_WR_LEFT, i / 3, i % 3, EDGE_VALS[i]);
      queue_word(OP_WR_RIGHT, i / 2, i % 2, EDGE_VALS[5-i]);
    end
    queue_word(OP_COMPUTE, 0, 15, -16'sd1);
    queue_word(OP_COMPUTE, 1, 0, 16'sd0);
    queue_word(OP_COMPUTE, 2, 0, 16'sd0);
    queue_word(OP_COMPUTE, 15, 15, 16'sh7fff);
    queue_word(OP_WR_LEFT, 2, 0, 16'sd5);
    queue_word(OP_WR_LEFT, 0, 3, 16'sd5);
    queue_word(OP_WR_RIGHT, 3, 0, 16'sd5);
    queue_word(OP_WR_RIGHT, 0, 2, 16'sd5);
    queue_word(OP_UNUSED, 15, 15, 16'sh8000);
    queue_word(OP_UNUSED, 0, 0, 16'sd0);
    settle(HOLD_OFF);

    // zero sizes act as one
    write_sizes(5'd0, 5'd0, 5'd0, 69);
    queue_random_words(50);
    settle(HOLD_OFF);

    // full inner size: largest and most negative sums first
    write_sizes(5'd31, 5'd16, 5'd1, 0);
    for (int k = 0; k < DIM; k++) begin
      queue_word(OP_WR_LEFT, 15, k, 16'sh8000);
      queue_word(OP_WR_LEFT, 14, k, 16'sh7fff);
      queue_word(OP_WR_RIGHT, k, 0, 16'sh8000);
    end
    queue_word(OP_COMPUTE, 15, 0, 16'sd0);
    queue_word(OP_COMPUTE, 14, 15, -16'sd1);
    queue_random_words(45);
    settle(HOLD_OFF);

    // sixteen result columns per row
    write_sizes(5'd16, 5'd1, 5'd16, 26);
    queue_random_words(60);
    settle(HOLD_OFF);

    write_sizes(5'd3, 5'd5, 5'd4, 69);
    queue_random_words(60);
    settle(HOLD_OFF);

    // column register past the store size
    write_sizes(5'd6, 5'd2, 5'd20, 0);
    queue_random_words(60);
    settle(20);

    $display("Summary: %0d words taken (%0d row computes, %0d rejects), %0d results checked",
             words_taken, computes_taken, rejects_taken, results_checked);
    $display("Six size settings covered, including zero, sixteen and out-of-range values");
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

endmodule
